// ===== hdl/csvp_pkg.sv =====
package csvp_pkg;

   // Parser state codes.
   localparam logic [1:0] ST_START      = 2'd0;
   localparam logic [1:0] ST_UNQUOTED   = 2'd1;
   localparam logic [1:0] ST_QUOTED     = 2'd2;
   localparam logic [1:0] ST_QUOTE_SEEN = 2'd3;

   // Special characters.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Input item kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOI  = 1'b1;

   // Result kinds.
   localparam logic [2:0] OK_CONTENT = 3'd0;
   localparam logic [2:0] OK_FIELD   = 3'd1;
   localparam logic [2:0] OK_RECORD  = 3'd2;
   localparam logic [2:0] OK_BLANK   = 3'd3;
   localparam logic [2:0] OK_EOI     = 3'd4;

   // Reset value of the delimiter register (tab).
   localparam logic [7:0] DELIM_RESET = 8'h09;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      logic [1:0] pstate;
      logic       has_content;
      logic       skip_lf;
   } parse_state_type;

   // One result produced by the classifier.
   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] data;
   } result_type;

endpackage

// ===== hdl/csvp_classify.sv =====
module csvp_classify (
   input  csvp_pkg::parse_state_type cur_state,
   input  logic                      item_kind,
   input  logic [7:0]                item_byte,
   input  logic [7:0]                delimiter,
   output csvp_pkg::parse_state_type nxt_state,
   output csvp_pkg::result_type      result
);
   import csvp_pkg::*;

   logic [2:0] end_kind;
   logic       is_delim;

   assign end_kind = cur_state.has_content ? OK_RECORD : OK_BLANK;
   assign is_delim = (item_byte == delimiter);

   // Classify one byte against the current parser state.
   always_comb begin
      nxt_state         = cur_state;
      nxt_state.skip_lf = 1'b0;
      result.valid      = 1'b1;
      result.kind       = OK_CONTENT;
      result.data       = 8'd0;

      if (item_kind == KIND_EOI) begin
         // End of input closes any open record and restarts the stream.
         nxt_state.pstate      = ST_START;
         nxt_state.has_content = 1'b0;
         result.kind           = cur_state.has_content ? OK_RECORD : OK_EOI;
      end else if (cur_state.skip_lf && item_byte == CH_LF) begin
         // Second half of a CRLF pair is swallowed.
         result.valid = 1'b0;
      end else begin
         case (cur_state.pstate)
            ST_QUOTED: begin
               if (item_byte == CH_QUOTE) begin
                  nxt_state.pstate = ST_QUOTE_SEEN;
                  result.valid     = 1'b0;
               end else if (item_byte == CH_CR) begin
                  nxt_state.skip_lf = 1'b1;
                  result.data       = CH_LF;
               end else begin
                  result.data = item_byte;
               end
            end
            ST_QUOTE_SEEN: begin
               if (item_byte == CH_QUOTE) begin
                  nxt_state.pstate = ST_QUOTED;
                  result.data      = CH_QUOTE;
               end else if (is_delim) begin
                  nxt_state.pstate = ST_START;
                  result.kind      = OK_FIELD;
               end else if (item_byte == CH_LF || item_byte == CH_CR) begin
                  nxt_state.pstate      = ST_START;
                  nxt_state.has_content = 1'b0;
                  nxt_state.skip_lf     = (item_byte == CH_CR);
                  result.kind           = end_kind;
               end else begin
                  nxt_state.pstate = ST_UNQUOTED;
                  result.data      = item_byte;
               end
            end
            default: begin
               if (item_byte == CH_QUOTE && cur_state.pstate == ST_START) begin
                  nxt_state.has_content = 1'b1;
                  nxt_state.pstate      = ST_QUOTED;
                  result.valid          = 1'b0;
               end else if (is_delim) begin
                  nxt_state.has_content = 1'b1;
                  nxt_state.pstate      = ST_START;
                  result.kind           = OK_FIELD;
               end else if (item_byte == CH_LF || item_byte == CH_CR) begin
                  nxt_state.pstate      = ST_START;
                  nxt_state.has_content = 1'b0;
                  nxt_state.skip_lf     = (item_byte == CH_CR);
                  result.kind           = end_kind;
               end else begin
                  nxt_state.has_content = 1'b1;
                  nxt_state.pstate      = ST_UNQUOTED;
                  result.data           = item_byte;
               end
            end
         endcase
      end
   end

endmodule

// ===== hdl/csv_record_parser.sv =====
// CSV record parser: classifies a byte stream under RFC 4180 quoting rules.
// Input channel (req_*): one byte or an end-of-input mark per transaction.
// Result channel (rsp_*): at most one result per input transaction: a content
// byte, a field end, a record end, a blank record or an end of input.
// Configuration channel (csr_*): writes the field delimiter; always ready.
// Write it only while no transaction is in flight.
// An accepted byte first waits in the input register, then loads the result
// register, which drives rsp_valid.
// Throughput: one byte per cycle while the receiver does not stall; the input
// register holds one byte while the result register holds one result.
// When the receiver stalls, the result register holds, the byte behind it
// stays in the input register, and req_ready drops until rsp_ready returns.
// Bytes that produce no result never occupy the result register.
// Reset clears both pipeline registers and the parser state and loads a tab
// as the delimiter.
module csv_record_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_delimiter
);
   import csvp_pkg::*;

   logic            in_valid_ff;
   logic            in_kind_ff;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   logic [2:0]      out_kind_ff;
   logic [7:0]      out_byte_ff;
   logic [7:0]      delim_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result;
   logic            out_free;
   logic            advance;

   assign csr_ready = 1'b1;

   // The input register moves on whenever the result register can take a value.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   csvp_classify u_classify (
      .cur_state (state_ff),
      .item_kind (in_kind_ff),
      .item_byte (in_byte_ff),
      .delimiter (delim_ff),
      .nxt_state (state_in),
      .result    (result)
   );

   // Delimiter register.
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
      end else if (csr_valid && csr_ready) begin
         delim_ff <= csr_delimiter;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_in_byte;
      end
   end

   // Parser state advances with each byte leaving the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{pstate: ST_START, has_content: 1'b0, skip_lf: 1'b0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_kind_ff <= result.kind;
         out_byte_ff <= result.data;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_kind = out_kind_ff;
   assign rsp_out_byte = out_byte_ff;

endmodule

// ===== hdl/csvp_checker.sv =====
module csvp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte
);
   import csvp_pkg::*;

   // No result is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind)
         && $stable(rsp_out_byte))
      else $error("stalled result changed");

   // Result kinds stay within the defined codes.
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_kind <= OK_EOI)
      else $error("undefined result kind");

   // Only content results carry a byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != OK_CONTENT |-> rsp_out_byte == 8'd0)
      else $error("non-content result carries a byte");

   // A stalled receiver with a full pipeline backs up into the input channel
   // until the receiver takes the waiting result.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && req_valid && req_ready |=> !req_ready || rsp_ready)
      else $error("input accepted past a full pipeline");

endmodule

bind csv_record_parser csvp_checker u_csvp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_kind (rsp_out_kind),
   .rsp_out_byte (rsp_out_byte)
);
